// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include guarded
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/prs80_pkg.sv =====
// constants, s-box tables and round functions for the present-80 core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package prs80_pkg;

	localparam int ROUNDS   = 31;
	localparam int NUM_KEYS = 32;

	// configuration register indexes (selected by paddr[3])
	localparam logic REG_KEY_HIGH = 1'b0;
	localparam logic REG_KEY_LOW  = 1'b1;

	localparam logic [3:0] SBOX_FWD [16] = '{
		4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
		4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
	};
	localparam logic [3:0] SBOX_INV [16] = '{
		4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
		4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
	};

	function automatic logic [63:0] sub_layer(input logic [63:0] s);
		logic [63:0] o;
		o = '0;
		for (int n = 0; n < 16; n++) begin
			o[4*n +: 4] = SBOX_FWD[s[4*n +: 4]];
		end
		return o;
	endfunction

	function automatic logic [63:0] sub_layer_inv(input logic [63:0] s);
		logic [63:0] o;
		o = '0;
		for (int n = 0; n < 16; n++) begin
			o[4*n +: 4] = SBOX_INV[s[4*n +: 4]];
		end
		return o;
	endfunction

	// bit i moves to 16*i mod 63 (bit 63 stays): a 6-bit rotate left by 4
	function automatic logic [5:0] perm_pos(input logic [5:0] i);
		return {i[1:0], i[5:2]};
	endfunction

	function automatic logic [63:0] perm_fwd(input logic [63:0] s);
		logic [63:0] o;
		o = '0;
		for (int i = 0; i < 64; i++) begin
			o[perm_pos(6'(i))] = s[i];
		end
		return o;
	endfunction

	function automatic logic [63:0] perm_back(input logic [63:0] s);
		logic [63:0] o;
		o = '0;
		for (int i = 0; i < 64; i++) begin
			o[i] = s[perm_pos(6'(i))];
		end
		return o;
	endfunction

	// one key schedule step on the 80-bit register, c is the round counter
	function automatic logic [79:0] key_step(input logic [79:0] k, input logic [4:0] c);
		logic [79:0] r;
		r = {k[18:0], k[79:19]};
		r[79:76] = SBOX_FWD[r[79:76]];
		r[19:15] = r[19:15] ^ c;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/present80_block_cipher_core.sv =====
// present-80 encrypt/decrypt core, one round per pipeline stage
// depends on prs80_pkg
`timescale 1ns / 1ps
`default_nettype none

// channel   | ports                                        | transaction
// ----------+----------------------------------------------+----------------------------------
// request   | start, busy, req_type, data_in               | start high while busy low
// result    | done, data_out                               | done high for one cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata | apb write when psel/penable/pwrite
//
// a new request can enter every cycle while busy is low
// a request passes the input register, the 31 round stages and the output register before done
// after reset and after every key write the round key table is rebuilt by a
// sweep of the key schedule over all 32 round keys; busy is high during the sweep
// the result side cannot stall, so the pipeline never holds
module present80_block_cipher_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request
	input  wire logic        start,
	output logic             busy,
	input  wire logic        req_type,
	input  wire logic [63:0] data_in,
	// result
	output logic             done,
	output logic [63:0]      data_out,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	localparam int LAST_KEY = prs80_pkg::NUM_KEYS - 1;

	// key registers
	logic [63:0] key_high_q;
	logic [15:0] key_low_q;

	// key schedule sweep
	logic [79:0] sched_q;
	logic [4:0]  rk_cnt_q;
	logic        sweep_q;
	logic [63:0] rk_q [prs80_pkg::NUM_KEYS];

	// round pipeline
	logic [63:0] data_s [prs80_pkg::ROUNDS + 1];
	logic        dec_s  [prs80_pkg::ROUNDS + 1];
	logic        vld_s  [prs80_pkg::ROUNDS + 1];

	logic        done_q;
	logic [63:0] data_out_q;

	logic cfg_wr;
	logic accept;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign accept = start && !busy;
	assign busy   = sweep_q;

	always_comb begin
		case (paddr[3])
			prs80_pkg::REG_KEY_HIGH: prdata = key_high_q;
			prs80_pkg::REG_KEY_LOW:  prdata = {48'd0, key_low_q};
			default:                 prdata = '0;
		endcase
	end

	// key registers and schedule sweep; a key write restarts the sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			sched_q    <= '0;
			rk_cnt_q   <= '0;
			sweep_q    <= 1'b1;
		end else if (cfg_wr) begin
			rk_cnt_q <= '0;
			sweep_q  <= 1'b1;
			case (paddr[3])
				prs80_pkg::REG_KEY_HIGH: begin
					key_high_q <= pwdata;
					sched_q    <= {pwdata, key_low_q};
				end
				prs80_pkg::REG_KEY_LOW: begin
					key_low_q <= pwdata[15:0];
					sched_q   <= {key_high_q, pwdata[15:0]};
				end
				default: begin
					sched_q <= {key_high_q, key_low_q};
				end
			endcase
		end else if (sweep_q) begin
			sched_q  <= prs80_pkg::key_step(sched_q, rk_cnt_q + 5'd1);
			rk_cnt_q <= rk_cnt_q + 5'd1;
			if (rk_cnt_q == 5'(LAST_KEY)) begin
				sweep_q <= 1'b0;
			end
		end
	end

	// round key table, round key i is the top 64 bits of the schedule
	always_ff @(posedge clk) begin
		if (sweep_q && !cfg_wr) begin
			rk_q[rk_cnt_q] <= sched_q[79:16];
		end
	end

	// input stage: decryption starts with the last round key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		data_s[0] <= req_type ? (data_in ^ rk_q[LAST_KEY]) : data_in;
		dec_s[0]  <= req_type;
	end

	// one round per stage; decryption walks the round keys backward
	for (genvar k = 0; k < prs80_pkg::ROUNDS; k++) begin : g_round
		logic [63:0] enc_nx;
		logic [63:0] dec_nx;

		always_comb begin
			enc_nx = prs80_pkg::perm_fwd(prs80_pkg::sub_layer(data_s[k] ^ rk_q[k]));
			dec_nx = prs80_pkg::sub_layer_inv(prs80_pkg::perm_back(data_s[k]))
				^ rk_q[prs80_pkg::ROUNDS - 1 - k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k + 1] <= 1'b0;
			end else begin
				vld_s[k + 1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			data_s[k + 1] <= dec_s[k] ? dec_nx : enc_nx;
			dec_s[k + 1]  <= dec_s[k];
		end
	end

	// output stage: encryption ends with the last round key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[prs80_pkg::ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		data_out_q <= dec_s[prs80_pkg::ROUNDS] ? data_s[prs80_pkg::ROUNDS]
			: (data_s[prs80_pkg::ROUNDS] ^ rk_q[LAST_KEY]);
	end

	assign done     = done_q;
	assign data_out = data_out_q;

endmodule

`default_nettype wire

// ===== src/prs80_checker.sv =====
// port-level checks for the present-80 core, bound into present80_block_cipher_core
// depends on assert_macros.svh and present80_block_cipher_core
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module prs80_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic pready
);

	`ASSERT_ALWAYS(a_pready_high, clk, arst_n, pready, "pready dropped")
	`ASSERT_NEXT(a_busy_after_wr, clk, arst_n, psel && penable && pwrite, busy, "no key sweep")
	`ASSERT_IMPLIES(a_done_latency, clk, arst_n, start && !busy, ##33 done, "late result")
	`ASSERT_IMPLIES(a_done_cause, clk, arst_n, done, $past(start && !busy, 33), "stray result")

endmodule

bind present80_block_cipher_core prs80_checker u_prs80_checker (.*);

`default_nettype wire
